// ===== rtl/core/qvr_pkg.sv =====
// qvr_pkg: shared types and constants for the quaternion vector rotation block
// request and result payload structs, fixed Q16.16 field width
// no dependencies
package qvr_pkg;

    localparam int DATA_WIDTH = 32;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_real;
        logic signed [DATA_WIDTH-1:0] quat_i;
        logic signed [DATA_WIDTH-1:0] quat_j;
        logic signed [DATA_WIDTH-1:0] quat_k;
        logic signed [DATA_WIDTH-1:0] vec_x;
        logic signed [DATA_WIDTH-1:0] vec_y;
        logic signed [DATA_WIDTH-1:0] vec_z;
    } qvr_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_x;
        logic signed [DATA_WIDTH-1:0] out_y;
        logic signed [DATA_WIDTH-1:0] out_z;
        logic                         zero_quat;
        logic                         overflow;
    } qvr_result_t;

endpackage

// ===== rtl/core/qvr_mul.sv =====
// qvr_mul: two-stage signed multiplier, wide operand split into chunks
// chunk partial products registered, then shifted and summed into a register
// no package dependencies
module qvr_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int RW = 64
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [RW-1:0] p
);

    localparam int CW   = BW;
    localparam int NC   = (AW + CW - 1) / CW;
    localparam int PADW = NC * CW;
    localparam int PPW  = CW + 1 + BW;

    logic signed [PADW-1:0] a_ext;
    logic signed [PPW-1:0]  pp_reg [NC];
    logic signed [RW-1:0]   sum;
    logic signed [RW-1:0]   p_reg;

    assign a_ext = PADW'(a);

    for (genvar i = 0; i < NC; i++) begin : g_chunk
        logic signed [CW:0]    chunk;
        logic signed [PPW-1:0] prod;

        // top chunk carries the sign, lower chunks are unsigned
        if (i == NC - 1) begin : g_top
            assign chunk = {a_ext[PADW-1], a_ext[i*CW +: CW]};
        end
        else begin : g_low
            assign chunk = {1'b0, a_ext[i*CW +: CW]};
        end

        assign prod = chunk * b;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_reg[i] <= prod;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NC; i++)
        begin
            sum = sum + (RW'(pp_reg[i]) <<< (i * CW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/qvr_div.sv =====
// qvr_div: pipelined restoring divider, one quotient bit per stage
// computes round(N / n) ties away from zero, then saturates to W bits
// no package dependencies
module qvr_div #(
    parameter int W  = 32,
    parameter int PW = 100,
    parameter int DW = 66
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [PW-1:0] num,
    input  logic [DW-1:0]        nrm,
    output logic signed [W-1:0]  quo,
    output logic                 ovf
);

    localparam int QB = W + 1;
    localparam logic [QB-1:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

    logic [DW-1:0] rem_reg [QB+1];
    logic [QB-1:0] lo_reg  [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic [DW-1:0] den_reg [QB+1];
    logic          neg_reg [QB+1];

    logic [PW-1:0] mag;
    logic [PW-1:0] dvd;

    logic [QB-1:0] lim;
    logic          sat;
    logic [QB-1:0] val;
    logic [QB-1:0] res;
    logic signed [W-1:0] quo_reg;
    logic          ovf_reg;

    // dividend 2|N| + n over divisor 2n gives the rounded quotient
    assign mag = num[PW-1] ? PW'(-num) : PW'(num);
    assign dvd = (mag << 1) + PW'(nrm);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(dvd >> QB);
            lo_reg[0]  <= dvd[QB-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= {nrm[DW-2:0], 1'b0};
            neg_reg[0] <= num[PW-1];
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[k-1], lo_reg[k-1][QB-k]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                lo_reg[k]  <= lo_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign lim = neg_reg[QB] ? LIM_NEG : LIM_POS;
    assign sat = q_reg[QB] > lim;
    assign val = sat ? lim : q_reg[QB];
    assign res = neg_reg[QB] ? (~val + QB'(1)) : val;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= res[W-1:0];
            ovf_reg <= sat;
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule

// ===== rtl/core/quaternion_vector_rotate_top.sv =====
// quaternion_vector_rotate_top: rotates a vector by q v q* / |q|^2, Q16.16
// uses qvr_pkg, qvr_mul, qvr_div
// Accepts one request per cycle while the output is not held and returns one
// result per request, in order, after an input stage, two pipelined multiply
// layers of two stages each with an add stage between and after them, and a
// restoring divider with a load stage, one quotient bit per stage and a
// rounding stage, followed by the output register. The divider depth sets
// the latency. When the output is held by result_ready the whole pipeline
// holds and item_ready drops in the same cycle; nothing is lost or repeated.
// An all-zero quaternion passes the vector through with zero_quat set.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  qvr_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output qvr_result_t result
);

    localparam int W       = DATA_WIDTH;
    localparam int SW      = 2 * W + 2;
    localparam int PW      = 3 * W + 4;
    localparam int DIV_LAT = W + 3;
    localparam int VL      = 7 + DIV_LAT;

    typedef struct packed {
        logic                zq;
        logic signed [W-1:0] qw;
        logic signed [W-1:0] qx;
        logic signed [W-1:0] qy;
        logic signed [W-1:0] qz;
        logic signed [W-1:0] va;
        logic signed [W-1:0] vb;
        logic signed [W-1:0] vc;
    } side1_t;

    typedef struct packed {
        logic                 zq;
        logic signed [SW-1:0] n;
        logic signed [W-1:0]  va;
        logic signed [W-1:0]  vb;
        logic signed [W-1:0]  vc;
    } side2_t;

    typedef struct packed {
        logic                zq;
        logic signed [W-1:0] va;
        logic signed [W-1:0] vb;
        logic signed [W-1:0] vc;
    } side3_t;

    logic en;
    logic vld_reg [VL];
    logic result_valid_reg;
    qvr_result_t result_reg;

    side1_t s0_reg, s1_reg, s2_reg;
    side2_t s4_reg, s5_reg, s6_reg;
    side3_t d_reg [DIV_LAT];

    // first multiply layer: ww xx yy zz xa yb zc yc zb za xc xb ya
    logic signed [W-1:0]   m1a [13];
    logic signed [W-1:0]   m1b [13];
    logic signed [2*W-1:0] m1p [13];

    logic signed [SW-1:0] n3_reg, s3_reg, d23_reg, cx3_reg, cy3_reg, cz3_reg;
    logic signed [W:0]    w23_reg;
    logic signed [W-1:0]  x3_reg, y3_reg, z3_reg, a3_reg, b3_reg, c3_reg;
    logic                 zq3_reg;

    // second multiply layer: per axis s*v, 2d*q, 2w*cross
    logic signed [SW-1:0] m2a [9];
    logic signed [W:0]    m2b [9];
    logic signed [PW-1:0] m2p [9];

    logic signed [PW-1:0] nx6_reg, ny6_reg, nz6_reg;
    logic signed [W-1:0]  qo [3];
    logic                 qv [3];

    // whole pipeline advances unless a finished result is held
    assign en         = !result_valid_reg || result_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VL; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < VL; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            result_valid_reg <= vld_reg[VL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg.zq <= (item.quat_real == '0) && (item.quat_i == '0) &&
                         (item.quat_j == '0) && (item.quat_k == '0);
            s0_reg.qw <= item.quat_real;
            s0_reg.qx <= item.quat_i;
            s0_reg.qy <= item.quat_j;
            s0_reg.qz <= item.quat_k;
            s0_reg.va <= item.vec_x;
            s0_reg.vb <= item.vec_y;
            s0_reg.vc <= item.vec_z;
            s1_reg    <= s0_reg;
            s2_reg    <= s1_reg;
        end
    end

    always_comb
    begin
        m1a[0]  = s0_reg.qw; m1b[0]  = s0_reg.qw;
        m1a[1]  = s0_reg.qx; m1b[1]  = s0_reg.qx;
        m1a[2]  = s0_reg.qy; m1b[2]  = s0_reg.qy;
        m1a[3]  = s0_reg.qz; m1b[3]  = s0_reg.qz;
        m1a[4]  = s0_reg.qx; m1b[4]  = s0_reg.va;
        m1a[5]  = s0_reg.qy; m1b[5]  = s0_reg.vb;
        m1a[6]  = s0_reg.qz; m1b[6]  = s0_reg.vc;
        m1a[7]  = s0_reg.qy; m1b[7]  = s0_reg.vc;
        m1a[8]  = s0_reg.qz; m1b[8]  = s0_reg.vb;
        m1a[9]  = s0_reg.qz; m1b[9]  = s0_reg.va;
        m1a[10] = s0_reg.qx; m1b[10] = s0_reg.vc;
        m1a[11] = s0_reg.qx; m1b[11] = s0_reg.vb;
        m1a[12] = s0_reg.qy; m1b[12] = s0_reg.va;
    end

    for (genvar i = 0; i < 13; i++) begin : g_mul1
        qvr_mul #(
            .AW (W),
            .BW (W),
            .RW (2 * W)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .a   (m1a[i]),
            .b   (m1b[i]),
            .p   (m1p[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_reg  <= SW'(m1p[0]) + SW'(m1p[1]) + SW'(m1p[2]) + SW'(m1p[3]);
            s3_reg  <= SW'(m1p[0]) - SW'(m1p[1]) - SW'(m1p[2]) - SW'(m1p[3]);
            d23_reg <= (SW'(m1p[4]) + SW'(m1p[5]) + SW'(m1p[6])) <<< 1;
            cx3_reg <= SW'(m1p[7]) - SW'(m1p[8]);
            cy3_reg <= SW'(m1p[9]) - SW'(m1p[10]);
            cz3_reg <= SW'(m1p[11]) - SW'(m1p[12]);
            w23_reg <= {s2_reg.qw, 1'b0};
            x3_reg  <= s2_reg.qx;
            y3_reg  <= s2_reg.qy;
            z3_reg  <= s2_reg.qz;
            a3_reg  <= s2_reg.va;
            b3_reg  <= s2_reg.vb;
            c3_reg  <= s2_reg.vc;
            zq3_reg <= s2_reg.zq;
        end
    end

    always_comb
    begin
        m2a[0] = s3_reg;  m2b[0] = (W+1)'(a3_reg);
        m2a[1] = d23_reg; m2b[1] = (W+1)'(x3_reg);
        m2a[2] = cx3_reg; m2b[2] = w23_reg;
        m2a[3] = s3_reg;  m2b[3] = (W+1)'(b3_reg);
        m2a[4] = d23_reg; m2b[4] = (W+1)'(y3_reg);
        m2a[5] = cy3_reg; m2b[5] = w23_reg;
        m2a[6] = s3_reg;  m2b[6] = (W+1)'(c3_reg);
        m2a[7] = d23_reg; m2b[7] = (W+1)'(z3_reg);
        m2a[8] = cz3_reg; m2b[8] = w23_reg;
    end

    for (genvar i = 0; i < 9; i++) begin : g_mul2
        qvr_mul #(
            .AW (SW),
            .BW (W + 1),
            .RW (PW)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .a   (m2a[i]),
            .b   (m2b[i]),
            .p   (m2p[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg.zq <= zq3_reg;
            s4_reg.n  <= n3_reg;
            s4_reg.va <= a3_reg;
            s4_reg.vb <= b3_reg;
            s4_reg.vc <= c3_reg;
            s5_reg    <= s4_reg;
            s6_reg    <= s5_reg;
            nx6_reg   <= m2p[0] + m2p[1] + m2p[2];
            ny6_reg   <= m2p[3] + m2p[4] + m2p[5];
            nz6_reg   <= m2p[6] + m2p[7] + m2p[8];
        end
    end

    qvr_div #(.W (W), .PW (PW), .DW (SW)) u_div_x (
        .clk (clk), .en (en), .num (nx6_reg), .nrm (s6_reg.n), .quo (qo[0]), .ovf (qv[0])
    );

    qvr_div #(.W (W), .PW (PW), .DW (SW)) u_div_y (
        .clk (clk), .en (en), .num (ny6_reg), .nrm (s6_reg.n), .quo (qo[1]), .ovf (qv[1])
    );

    qvr_div #(.W (W), .PW (PW), .DW (SW)) u_div_z (
        .clk (clk), .en (en), .num (nz6_reg), .nrm (s6_reg.n), .quo (qo[2]), .ovf (qv[2])
    );

    // pass-through data rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0].zq <= s6_reg.zq;
            d_reg[0].va <= s6_reg.va;
            d_reg[0].vb <= s6_reg.vb;
            d_reg[0].vc <= s6_reg.vc;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                d_reg[i] <= d_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_reg[DIV_LAT-1].zq)
            begin
                result_reg.out_x     <= d_reg[DIV_LAT-1].va;
                result_reg.out_y     <= d_reg[DIV_LAT-1].vb;
                result_reg.out_z     <= d_reg[DIV_LAT-1].vc;
                result_reg.zero_quat <= 1'b1;
                result_reg.overflow  <= 1'b0;
            end
            else
            begin
                result_reg.out_x     <= qo[0];
                result_reg.out_y     <= qo[1];
                result_reg.out_z     <= qo[2];
                result_reg.zero_quat <= 1'b0;
                result_reg.overflow  <= qv[0] | qv[1] | qv[2];
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/qvr_checker.sv =====
// qvr_props: port-level checks for quaternion_vector_rotate_top
// uses qvr_pkg; bound to the top level at the end of this file
module qvr_props
    import qvr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input qvr_item_t   item,
    input logic        result_valid,
    input logic        result_ready,
    input qvr_result_t result
);

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // an empty output stage never blocks a request
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("request blocked with empty output");

    // pass-through never reports saturation
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_quat |-> !result.overflow)
        else $error("overflow on zero quaternion");

    // overflow means some component sits at a limit
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |->
            (result.out_x == SMAX) || (result.out_x == SMIN) ||
            (result.out_y == SMAX) || (result.out_y == SMIN) ||
            (result.out_z == SMAX) || (result.out_z == SMIN))
        else $error("overflow without saturated component");

endmodule

bind quaternion_vector_rotate_top qvr_props u_qvr_props (.*);
